@@ hw/rtl/ula_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ula_pkg;

    localparam int BYTE_W   = 8;
    localparam int LENGTH_W = 6;

    localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;

    localparam logic KIND_LINE     = 1'b0;
    localparam logic KIND_OVERFLOW = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHOW,
        ST_OVERFLOW
    } state_t;

    // Line terminators: LF, CR and NUL
    function automatic logic is_terminator(input logic [BYTE_W-1:0] c);
        return (c == CHAR_LF) || (c == CHAR_CR) || (c == CHAR_NUL);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ula_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Received byte channel
interface ula_rx_if;
    logic                         valid;
    logic                         ready;
    logic [ula_pkg::BYTE_W-1:0]   rx_byte;
    logic                         framing_error;
    logic                         overrun_error;

    modport source (output valid, output rx_byte, output framing_error,
                    output overrun_error, input ready);
    modport sink   (input valid, input rx_byte, input framing_error,
                    input overrun_error, output ready);
endinterface

// Result channel
interface ula_res_if;
    logic                         valid;
    logic                         ready;
    logic                         result_kind;
    logic [ula_pkg::BYTE_W-1:0]   line_byte;
    logic [ula_pkg::LENGTH_W-1:0] line_length;
    logic                         last;

    modport source (output valid, output result_kind, output line_byte,
                    output line_length, output last, input ready);
    modport sink   (input valid, input result_kind, input line_byte,
                    input line_length, input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ula_line_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ula_line_store #(
    parameter int DEPTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  wire logic [ula_pkg::BYTE_W-1:0]       wr_data,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic      [ula_pkg::BYTE_W-1:0]       rd_data
);

    logic [ula_pkg::BYTE_W-1:0] mem [DEPTH];

    // Write one character
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read with registered data; hold when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/uart_line_assembler_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// UART receive line assembler. Each received byte transaction on rx is taken
// while idle: bytes with a framing or overrun error are dropped, ordinary bytes
// are written into a LINE_DEPTH-entry line memory, and a terminator (LF, CR or
// NUL) on an empty line is ignored. A terminator on a non-empty line of N bytes
// drains the line as N result transactions, each carrying the byte, the line
// length and a last flag; the single read port of the line memory reads each
// byte in ST_READ before ST_SHOW presents it; res may stall each result. When
// the line is full, the next error-free byte of any value empties it and gives
// one overflow result. rx is not ready while results are being delivered. No
// clearing pass after reset is needed: the fill count marks which entries hold
// data. A line of 64 bytes reports its length modulo 64.
module uart_line_assembler_core #(
    parameter int LINE_DEPTH = 32
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ula_rx_if.sink        rx,
    ula_res_if.source     res
);

    localparam int IDX_W = $clog2(LINE_DEPTH);
    localparam int CNT_W = $clog2(LINE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(LINE_DEPTH);

    ula_pkg::state_t            state_reg, state_next;
    logic [CNT_W-1:0]           fill_reg, fill_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [CNT_W-1:0]           len_reg, len_next;

    logic                       res_accept;
    logic                       is_last;
    logic                       wr_en;
    logic                       rd_en;
    logic [ula_pkg::BYTE_W-1:0] rd_data;

    assign res_accept = res.valid && res.ready;
    assign is_last    = ((CNT_W'(idx_reg) + CNT_W'(1)) == len_reg);

    ula_line_store #(
        .DEPTH (LINE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[IDX_W-1:0]),
        .wr_data (rx.rx_byte),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ula_pkg::ST_IDLE;
            fill_reg  <= '0;
            idx_reg   <= '0;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
        end
    end

    // Sequence append, drain and overflow
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        idx_next        = idx_reg;
        len_next        = len_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rx.ready        = 1'b0;
        res.valid       = 1'b0;
        res.result_kind = ula_pkg::KIND_LINE;
        res.line_byte   = '0;
        res.line_length = '0;
        res.last        = 1'b0;

        case (state_reg)
            ula_pkg::ST_IDLE:
            begin
                rx.ready = 1'b1;
                if (rx.valid && !rx.framing_error && !rx.overrun_error)
                begin
                    if (fill_reg == FULL_COUNT)
                    begin
                        fill_next  = '0;
                        state_next = ula_pkg::ST_OVERFLOW;
                    end
                    else if (!ula_pkg::is_terminator(rx.rx_byte))
                    begin
                        wr_en     = 1'b1;
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    else if (fill_reg != '0)
                    begin
                        len_next   = fill_reg;
                        idx_next   = '0;
                        state_next = ula_pkg::ST_READ;
                    end
                end
            end

            ula_pkg::ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ula_pkg::ST_SHOW;
            end

            ula_pkg::ST_SHOW:
            begin
                res.valid       = 1'b1;
                res.result_kind = ula_pkg::KIND_LINE;
                res.line_byte   = rd_data;
                res.line_length = ula_pkg::LENGTH_W'(len_reg);
                res.last        = is_last;
                if (res.ready)
                begin
                    if (is_last)
                    begin
                        fill_next  = '0;
                        state_next = ula_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ula_pkg::ST_READ;
                    end
                end
            end

            ula_pkg::ST_OVERFLOW:
            begin
                res.valid       = 1'b1;
                res.result_kind = ula_pkg::KIND_OVERFLOW;
                res.last        = 1'b1;
                if (res.ready)
                begin
                    state_next = ula_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ula_pkg::ST_IDLE;
            end
        endcase
    end

    // Check fill bound, drain bookkeeping and channel exclusion
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_COUNT)
        else $error("fill count beyond line depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !rx.ready)
        else $error("rx ready while a result is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_accept && res.last) |=> (fill_reg == '0))
        else $error("line not emptied after last result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ula_pkg::ST_SHOW) |-> (CNT_W'(idx_reg) < len_reg))
        else $error("drain index beyond line length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.result_kind == ula_pkg::KIND_OVERFLOW)
            |-> (res.last && fill_reg == '0))
        else $error("overflow result malformed");

endmodule

`default_nettype wire
